// ===== design/wind_terrain_adjust_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the wind terrain adjust unit
// ----------------------------------------------------------------------------
`ifndef WIND_TERRAIN_ADJUST_UNIT_ASSERT_SVH
`define WIND_TERRAIN_ADJUST_UNIT_ASSERT_SVH

// clocked on clk, quiet while rst_n is low
`define WTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== design/wta_pkg.sv =====
// ----------------------------------------------------------------------------
// wta_pkg
// Shared types and constants of the wind terrain adjust unit.
// ----------------------------------------------------------------------------
package wta_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int SIN_LAT        = 7;
  localparam int DIV_BITS       = 32;

  localparam logic [15:0] BASE_GAIN_RST  = 16'd16384;
  localparam logic [15:0] SLOPE_GAIN_RST = 16'd8192;
  localparam logic [15:0] CURVE_GAIN_RST = 16'd8192;
  localparam logic [14:0] MAX_SLOPE_RST  = 15'd0;

  // 2*pi in Q28 and turns per radian (65536 / 2pi) in Q16
  localparam logic [30:0] TWO_PI_Q28        = 31'd1686629713;
  localparam logic [29:0] TURNS_PER_RAD_Q16 = 30'd683565276;
  localparam logic [22:0] OMEGA_MAX         = 23'd4194304;
  localparam logic [15:0] SPEED_FLOOR       = 16'd26;
  localparam logic [14:0] TURN_MAX          = 15'd16384;
  localparam logic [15:0] QTR_TURN          = 16'd16384;
  localparam logic [15:0] TQTR_TURN         = 16'd49152;

  // odd Taylor terms of sin over one quadrant, Q30
  localparam logic [30:0] SIN_COEF [5] = '{
    31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026996, 31'd172271
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_GAIN,
    CFG_SLOPE_GAIN,
    CFG_CURVE_GAIN,
    CFG_MAX_SLOPE
  } wta_cfg_idx_t;

  // item fields while the trig pipe works
  typedef struct packed {
    logic [15:0]        dir;
    logic [15:0]        spd;
    logic [14:0]        slope;
    logic signed [15:0] curv;
    logic               in_win;
  } wta_ipay_t;

  // item fields carried along the divider chain
  typedef struct packed {
    logic [15:0]        dir;
    logic [15:0]        spd;
    logic signed [15:0] curv;
    logic               in_win;
    logic               om_neg;
    logic [30:0]        sm;
    logic               s2neg;
  } wta_dpay_t;

endpackage

// ===== design/wta_sin.sv =====
// ----------------------------------------------------------------------------
// wta_sin
// Pipelined quadrant sine: 9th order odd polynomial, Horner steps in Q30.
// ----------------------------------------------------------------------------
module wta_sin #(
  parameter int ANGLE_BITS = wta_pkg::ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] ph,
  output logic [30:0]           mag,
  output logic                  neg
);
  import wta_pkg::*;

  localparam int FW  = ANGLE_BITS - 2;
  localparam int ZSH = 32 - ANGLE_BITS;

  logic [FW:0]   fq;
  logic [30:0]   z0;
  logic [61:0]   sq;
  logic [61:0]   fp;
  logic [31:0]   s;
  logic [61:0]   hp   [2:5];
  logic [30:0]   z_r  [6];
  logic [1:0]    q_r  [6];
  logic [30:0]   z2_r [1:4];
  logic [30:0]   t_r  [1:5];
  logic [30:0]   mag_r;
  logic          neg_r;

  always_comb begin
    fq = ph[ANGLE_BITS-2] ? ((FW+1)'(1) << FW) - {1'b0, ph[FW-1:0]}
                          : {1'b0, ph[FW-1:0]};
    z0 = 31'(fq) << ZSH;
    sq = 62'(z_r[0]) * 62'(z_r[0]);
    fp = 62'(z_r[5]) * 62'(t_r[5]);
    s  = fp[61:30];
    for (int i = 2; i <= 5; i++) begin
      hp[i] = 62'(z2_r[i-1]) * 62'(t_r[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r[0]  <= z0;
      q_r[0]  <= ph[ANGLE_BITS-1:ANGLE_BITS-2];
      for (int i = 1; i < 6; i++) begin
        z_r[i] <= z_r[i-1];
        q_r[i] <= q_r[i-1];
      end
      z2_r[1] <= sq[60:30];
      t_r[1]  <= SIN_COEF[4];
      for (int i = 2; i <= 5; i++) begin
        t_r[i] <= SIN_COEF[5-i] - hp[i][60:30];
      end
      for (int i = 2; i <= 4; i++) begin
        z2_r[i] <= z2_r[i-1];
      end
      // clamp to 1.0
      mag_r   <= (s > 32'h4000_0000) ? 31'h4000_0000 : s[30:0];
      neg_r   <= q_r[5][1] && (s != '0);
    end
  end

  assign mag = mag_r;
  assign neg = neg_r;

endmodule

// ===== design/wta_div_cell.sv =====
// ----------------------------------------------------------------------------
// wta_div_cell
// One restoring divider cell: settles one quotient bit and passes it on.
// ----------------------------------------------------------------------------
module wta_div_cell (
  input  logic                clk,
  input  logic                en,
  input  logic [15:0]         divisor,
  input  logic [15:0]         rem_in,
  input  logic [31:0]         num_in,
  input  logic [31:0]         quo_in,
  input  wta_pkg::wta_dpay_t  pay_in,
  output logic [15:0]         rem_out,
  output logic [31:0]         num_out,
  output logic [31:0]         quo_out,
  output wta_pkg::wta_dpay_t  pay_out
);
  import wta_pkg::*;

  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;
  logic [15:0] rem_r;
  logic [31:0] num_r;
  logic [31:0] quo_r;
  wta_dpay_t   pay_r;

  always_comb begin
    trial = {rem_in, num_in[31]};
    diff  = trial - {1'b0, divisor};
    ge    = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= ge ? diff[15:0] : trial[15:0];
      num_r <= {num_in[30:0], 1'b0};
      quo_r <= {quo_in[30:0], ge};
      pay_r <= pay_in;
    end
  end

  assign rem_out = rem_r;
  assign num_out = num_r;
  assign quo_out = quo_r;
  assign pay_out = pay_r;

endmodule

// ===== design/wind_terrain_adjust_unit.sv =====
// ----------------------------------------------------------------------------
// wind_terrain_adjust_unit
// Pipeline from input accept to out_valid: 7 sine stages, 2 slope stages,
//   32 divider cells, 3 weighting stages, output register.
// Throughput: one item per cycle; the whole pipe holds while the output
//   register is full and stalled and the last stage holds an item.
// Reset (synchronous, rst_n low) empties the pipe and loads register defaults.
// ----------------------------------------------------------------------------
module wind_terrain_adjust_unit #(
  parameter int ANGLE_BITS = wta_pkg::ANGLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [15:0]                     in_wind_dir,
  input  logic [15:0]                     in_wind_speed,
  input  logic [14:0]                     in_terrain_slope,
  input  logic [15:0]                     in_terrain_aspect,
  input  logic signed [15:0]              in_curvature_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [15:0]                     out_adj_speed,
  output logic [15:0]                     out_adj_dir,
  output logic [14:0]                     out_divergence,
  input  logic                            cfg_we,
  input  logic [wta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wta_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wta_pkg::*;

  localparam int NV    = SIN_LAT + 2 + DIV_BITS + 3;
  localparam int PH_UP = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int PH_DN = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;

  // configuration
  logic [15:0] base_gain_r, slope_gain_r, curve_gain_r;
  logic [14:0] max_slope_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_gain_r  <= BASE_GAIN_RST;
      slope_gain_r <= SLOPE_GAIN_RST;
      curve_gain_r <= CURVE_GAIN_RST;
      max_slope_r  <= MAX_SLOPE_RST;
    end else if (cfg_we) begin
      case (wta_cfg_idx_t'(cfg_index))
        CFG_BASE_GAIN:  base_gain_r  <= cfg_data;
        CFG_SLOPE_GAIN: slope_gain_r <= cfg_data;
        CFG_CURVE_GAIN: curve_gain_r <= cfg_data;
        CFG_MAX_SLOPE:  max_slope_r  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // flow control
  logic          en;
  logic          out_free;
  logic [NV-1:0] v_r;
  logic          out_valid_r;

  assign out_free = out_ready | ~out_valid_r;
  assign en       = out_free | ~v_r[NV-1];
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        v_r <= {v_r[NV-2:0], in_valid};
      end
      if (out_free) begin
        out_valid_r <= v_r[NV-1];
      end
    end
  end

  // phases for cos(dir - aspect) and sin(2 * (aspect - dir))
  logic [15:0]               dc16, du16, ds16;
  logic [ANGLE_BITS+15:0]    phc_ext, phs_ext;
  logic [ANGLE_BITS-1:0]     ph_c, ph_s;
  wta_ipay_t                 ipay;

  always_comb begin
    dc16    = in_wind_dir - in_terrain_aspect + QTR_TURN;
    du16    = in_terrain_aspect - in_wind_dir;
    ds16    = {du16[14:0], 1'b0};
    phc_ext = (ANGLE_BITS + 16)'(dc16) << PH_UP;
    phs_ext = (ANGLE_BITS + 16)'(ds16) << PH_UP;
    ph_c    = ANGLE_BITS'(phc_ext >> PH_DN);
    ph_s    = ANGLE_BITS'(phs_ext >> PH_DN);
    ipay.dir    = in_wind_dir;
    ipay.spd    = in_wind_speed;
    ipay.slope  = in_terrain_slope;
    ipay.curv   = in_curvature_index;
    ipay.in_win = (du16 <= QTR_TURN) || (du16 >= TQTR_TURN);
  end

  logic [30:0] cm, sm;
  logic        c_neg, s_neg;

  wta_sin #(.ANGLE_BITS(ANGLE_BITS)) u_cos (
    .clk(clk), .en(en), .ph(ph_c), .mag(cm), .neg(c_neg)
  );

  wta_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sin2 (
    .clk(clk), .en(en), .ph(ph_s), .mag(sm), .neg(s_neg)
  );

  wta_ipay_t ip_r [SIN_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      ip_r[0] <= ipay;
      for (int i = 1; i < SIN_LAT; i++) begin
        ip_r[i] <= ip_r[i-1];
      end
    end
  end

  // wind slope magnitude before the divide, Q16
  logic [45:0] rp;
  logic [59:0] wp;
  logic [28:0] r_r;
  logic [31:0] wsr_r;
  wta_dpay_t   a2_pay, a2_r, a3_r;

  always_comb begin
    rp            = 46'(ip_r[SIN_LAT-1].slope) * 46'(cm);
    wp            = 60'(r_r) * 60'(TWO_PI_Q28);
    a2_pay.dir    = ip_r[SIN_LAT-1].dir;
    a2_pay.spd    = ip_r[SIN_LAT-1].spd;
    a2_pay.curv   = ip_r[SIN_LAT-1].curv;
    a2_pay.in_win = ip_r[SIN_LAT-1].in_win;
    a2_pay.om_neg = c_neg;
    a2_pay.sm     = sm;
    a2_pay.s2neg  = s_neg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r   <= rp[44:16];
      a2_r  <= a2_pay;
      wsr_r <= wp[59:28];
      a3_r  <= a2_r;
    end
  end

  // divider chain: wind slope / (2 * max_wind_slope)
  logic [15:0] divisor;
  logic [15:0] rem_w [DIV_BITS+1];
  logic [31:0] num_w [DIV_BITS+1];
  logic [31:0] quo_w [DIV_BITS+1];
  wta_dpay_t   pay_w [DIV_BITS+1];

  assign divisor  = {max_slope_r, 1'b0};
  assign rem_w[0] = '0;
  assign num_w[0] = wsr_r;
  assign quo_w[0] = '0;
  assign pay_w[0] = a3_r;

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    wta_div_cell u_cell (
      .clk(clk), .en(en), .divisor(divisor),
      .rem_in(rem_w[k]), .num_in(num_w[k]), .quo_in(quo_w[k]), .pay_in(pay_w[k]),
      .rem_out(rem_w[k+1]), .num_out(num_w[k+1]), .quo_out(quo_w[k+1]),
      .pay_out(pay_w[k+1])
    );
  end

  // weighting and turn
  logic [22:0]        om_mag;
  logic [38:0]        sgp_nxt;
  logic [53:0]        p_nxt;
  logic signed [32:0] ct_nxt;
  logic [38:0]        sgp_r;
  logic [53:0]        p_r;
  logic signed [32:0] ct_r;
  wta_dpay_t          b1_r, b2_r, b3_r;
  logic signed [40:0] ww_nxt, ww_r;
  logic [60:0]        x_nxt;
  logic [59:0]        x_r;
  logic signed [57:0] prod_nxt, prod_r;
  logic [60:0]        tsum;
  logic [19:0]        turns20;
  logic [14:0]        turns_r;

  always_comb begin
    // a zero maximum gives a zero wind slope
    if (max_slope_r == '0) begin
      om_mag = '0;
    end else if (quo_w[DIV_BITS] > 32'(OMEGA_MAX)) begin
      om_mag = OMEGA_MAX;
    end else begin
      om_mag = quo_w[DIV_BITS][22:0];
    end
    sgp_nxt  = 39'(slope_gain_r) * 39'(om_mag);
    p_nxt    = 54'(om_mag) * 54'(pay_w[DIV_BITS].sm);
    ct_nxt   = 33'($signed({1'b0, curve_gain_r})) * 33'($signed(pay_w[DIV_BITS].curv));
    ww_nxt   = 41'($signed({1'b0, base_gain_r, 16'b0}))
             + (b1_r.om_neg ? -41'($signed({1'b0, sgp_r})) : 41'($signed({1'b0, sgp_r})))
             + 41'($signed({ct_r, 1'b0}));
    x_nxt    = 61'(p_r[52:22]) * 61'(TURNS_PER_RAD_Q16);
    prod_nxt = 58'($signed({1'b0, b2_r.spd})) * 58'(ww_r);
    tsum     = {1'b0, x_r} + (61'(1) << 40);
    turns20  = tsum[60:41];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sgp_r   <= sgp_nxt;
      p_r     <= p_nxt;
      ct_r    <= ct_nxt;
      b1_r    <= pay_w[DIV_BITS];
      ww_r    <= ww_nxt;
      x_r     <= x_nxt[59:0];
      b2_r    <= b1_r;
      prod_r  <= prod_nxt;
      turns_r <= (turns20 > 20'(TURN_MAX)) ? TURN_MAX : turns20[14:0];
      b3_r    <= b2_r;
    end
  end

  // output register
  logic [57:0] rsum;
  logic [27:0] rnd;
  logic [15:0] spd_out, dir_out;
  logic [15:0] adj_speed_r, adj_dir_r;
  logic [14:0] divergence_r;

  always_comb begin
    rsum = $unsigned(prod_r) + (58'(1) << 29);
    rnd  = rsum[57:30];
    if (prod_r[57] || (prod_r == '0)) begin
      spd_out = SPEED_FLOOR;
    end else if (|rnd[27:16]) begin
      spd_out = 16'hFFFF;
    end else if (rnd[15:0] < SPEED_FLOOR) begin
      spd_out = SPEED_FLOOR;
    end else begin
      spd_out = rnd[15:0];
    end
    dir_out = b3_r.dir;
    if (b3_r.in_win) begin
      // turn against the wind slope when both signs agree
      if (b3_r.om_neg == b3_r.s2neg) begin
        dir_out = b3_r.dir - {1'b0, turns_r};
      end else begin
        dir_out = b3_r.dir + {1'b0, turns_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && v_r[NV-1]) begin
      adj_speed_r  <= spd_out;
      adj_dir_r    <= dir_out;
      divergence_r <= turns_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_adj_speed  = adj_speed_r;
  assign out_adj_dir    = adj_dir_r;
  assign out_divergence = divergence_r;

endmodule

// ===== design/wta_checker.sv =====
// ----------------------------------------------------------------------------
// wta_checker
// Port level checks of the wind terrain adjust unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "wind_terrain_adjust_unit_assert.svh"

module wta_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [15:0]                     out_adj_speed,
  input logic [15:0]                     out_adj_dir,
  input logic [14:0]                     out_divergence
);

  logic [46:0] out_pay;

  assign out_pay = {out_adj_speed, out_adj_dir, out_divergence};

  // hold a stalled result
  `WTA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_pay), "stall moved")

  // speed never drops below the 0.1 m/s floor
  `WTA_ASSERT(a_speed_floor, out_valid |-> out_adj_speed >= 16'd26, "speed below floor")

  // turn never exceeds a quarter turn
  `WTA_ASSERT(a_turn_cap, out_valid |-> out_divergence <= 15'd16384, "turn above quarter")

  // input only backs up behind a stalled full output
  `WTA_ASSERT(a_ready, !in_ready |-> out_valid && !out_ready, "input stalled without cause")

endmodule

bind wind_terrain_adjust_unit wta_checker u_wta_checker (.*);
